// File: rtl/baf_pkg.sv
// Package for the box average filter: shared constants, register indexes, FSM state type.
// No dependencies.
`default_nettype none

package baf_pkg;

    // Default sizing of the frame store and window
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 15;

    // Configuration port
    localparam int CFG_DATA_W = 9;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic [8:0] RST_FRAME_WIDTH   = 9'd256;
    localparam logic [8:0] RST_FRAME_HEIGHT  = 9'd256;
    localparam logic [3:0] RST_WINDOW_RADIUS = 4'd1;

    localparam int PIX_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_WIN,
        ST_MUL,
        ST_READ,
        ST_DRAIN,
        ST_DIVLD,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/box_average_filter_unit.sv
// Box average filter: frame store plus sequential window mean engine.
// Depends on baf_pkg.
//
// Load transaction: written straight into the frame store.
// Drain transaction: position divide (YW restoring steps, 9 by default), window
//   bounds, window area and row base, window read loop (one store read per cycle),
//   drain, mean divide load, mean divide, then the result register.
// One transaction in work at a time; a finished result waits in the output
//   register while the next transaction is taken.
// Reset (aresetn, synchronous, active low): counters and frame flag cleared,
//   registers to 256/256/1. The frame store is not cleared.
`default_nettype none

module box_average_filter_unit #(
    parameter int MAX_WIDTH  = baf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = baf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = baf_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [baf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [baf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_kind,
    input  wire logic [baf_pkg::PIX_W-1:0]       s_pixel_in,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [baf_pkg::PIX_W-1:0]            m_pixel_out,
    output logic                                 m_frame_end
);

    // ---------------------------------------------------------------
    // Derived sizes
    // ---------------------------------------------------------------
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH) + 1;               // load/emit counters
    localparam int XW     = $clog2(MAX_WIDTH + 1);
    localparam int YW     = $clog2(MAX_HEIGHT + 1);
    localparam int RW     = $clog2(MAX_RADIUS + 2);
    localparam int FAW    = XW + YW;                         // frame area
    localparam int DVW    = CNT_W + YW;                      // position divider
    localparam int CW     = ((XW > YW) ? XW : YW) + RW + 1;  // window bound math
    localparam int DW     = $clog2(2 * MAX_RADIUS + 2);      // window span
    localparam int AW     = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SW     = AW + baf_pkg::CHAN_W;            // channel sum
    localparam int MXS    = (YW > baf_pkg::CHAN_W) ? YW : baf_pkg::CHAN_W;
    localparam int STW    = $clog2(MXS);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [8:0] frame_width_reg;
    logic [8:0] frame_height_reg;
    logic [3:0] window_radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= baf_pkg::RST_FRAME_WIDTH;
            frame_height_reg  <= baf_pkg::RST_FRAME_HEIGHT;
            window_radius_reg <= baf_pkg::RST_WINDOW_RADIUS;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                baf_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata[8:0];
                baf_pkg::REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[8:0];
                baf_pkg::REG_WINDOW_RADIUS: window_radius_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // Effective (clamped) dimensions and radius
    logic [XW-1:0]  w_eff;
    logic [YW-1:0]  h_eff;
    logic [RW-1:0]  r_eff;
    logic [FAW-1:0] frame_area;

    always_comb begin
        if (frame_width_reg == '0)                   w_eff = XW'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)  w_eff = XW'(MAX_WIDTH);
        else                                         w_eff = XW'(frame_width_reg);
        if (frame_height_reg == '0)                  h_eff = YW'(1);
        else if (32'(frame_height_reg) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
        else                                         h_eff = YW'(frame_height_reg);
        if (32'(window_radius_reg) > MAX_RADIUS)    r_eff = RW'(MAX_RADIUS);
        else                                         r_eff = RW'(window_radius_reg);
        frame_area = FAW'(w_eff) * FAW'(h_eff);
    end

    // ---------------------------------------------------------------
    // FSM and control state
    // ---------------------------------------------------------------
    baf_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] load_count_reg;
    logic [CNT_W-1:0] emit_count_reg;
    logic             frame_loaded_reg;
    logic [STW-1:0]   step_reg;
    logic             rd_pend_reg;
    logic             last_reg;
    logic             m_valid_reg;

    // Window walk
    logic [XW-1:0]  x1_reg, x2_reg, xi_reg;
    logic [YW-1:0]  y1_reg, y2_reg, yi_reg;
    logic [ADW-1:0] row_base_reg;

    // FSM outputs
    logic in_acc;
    logic rd_en;
    logic out_load;
    logic emit_go;
    logic row_end;
    logic win_end;

    assign in_acc  = s_valid && s_ready;
    assign emit_go = in_acc && s_kind && frame_loaded_reg
                     && (32'(emit_count_reg) < 32'(frame_area));
    assign row_end = (xi_reg == x2_reg);
    assign win_end = row_end && (yi_reg == y2_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            baf_pkg::ST_IDLE:  if (emit_go) state_next = baf_pkg::ST_POS;
            baf_pkg::ST_POS:   if (step_reg == '0) state_next = baf_pkg::ST_WIN;
            baf_pkg::ST_WIN:   state_next = baf_pkg::ST_MUL;
            baf_pkg::ST_MUL:   state_next = baf_pkg::ST_READ;
            baf_pkg::ST_READ:  if (win_end) state_next = baf_pkg::ST_DRAIN;
            baf_pkg::ST_DRAIN: state_next = baf_pkg::ST_DIVLD;
            baf_pkg::ST_DIVLD: state_next = baf_pkg::ST_DIV;
            baf_pkg::ST_DIV:   if (step_reg == '0) state_next = baf_pkg::ST_OUT;
            baf_pkg::ST_OUT:   if (!m_valid_reg || m_ready) state_next = baf_pkg::ST_IDLE;
            default:           state_next = baf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = (state_reg == baf_pkg::ST_IDLE);
        rd_en    = (state_reg == baf_pkg::ST_READ);
        out_load = (state_reg == baf_pkg::ST_OUT) && (!m_valid_reg || m_ready);
    end

    // Load bookkeeping: a load into a finished frame starts a new one
    logic [CNT_W-1:0] load_idx;
    logic [CNT_W-1:0] load_next;
    logic [CNT_W-1:0] emit_next;
    logic             load_done;
    logic             mem_we;

    always_comb begin
        load_idx  = frame_loaded_reg ? '0 : load_count_reg;
        load_next = load_idx + CNT_W'(1);
        load_done = (32'(load_next) >= 32'(frame_area));
        emit_next = emit_count_reg + CNT_W'(1);
        mem_we    = in_acc && !s_kind && (32'(load_idx) < DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= baf_pkg::ST_IDLE;
            load_count_reg   <= '0;
            emit_count_reg   <= '0;
            frame_loaded_reg <= 1'b0;
            rd_pend_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;

            if (in_acc && !s_kind) begin
                load_count_reg <= load_next;
                if (load_done) begin
                    frame_loaded_reg <= 1'b1;
                    emit_count_reg   <= '0;
                end else begin
                    frame_loaded_reg <= 1'b0;
                    if (frame_loaded_reg) emit_count_reg <= '0;
                end
            end else if (in_acc && s_kind && frame_loaded_reg) begin
                // emit: count now, end the frame on the last pixel or overrun
                if (!emit_go || (32'(emit_next) >= 32'(frame_area))) begin
                    frame_loaded_reg <= 1'b0;
                    load_count_reg   <= '0;
                    emit_count_reg   <= '0;
                end else begin
                    emit_count_reg <= emit_next;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Frame store: one write port, one registered read port
    // ---------------------------------------------------------------
    logic [baf_pkg::PIX_W-1:0] frame_mem [DEPTH];
    logic [baf_pkg::PIX_W-1:0] rd_data_reg;
    logic [ADW-1:0]            rd_addr;

    assign rd_addr = row_base_reg + ADW'(xi_reg);

    always_ff @(posedge aclk) begin
        if (mem_we)
            frame_mem[load_idx[ADW-1:0]] <= s_pixel_in;
        if (rd_en)
            rd_data_reg <= frame_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Datapath: position divide, window bounds, accumulate, mean divide
    // ---------------------------------------------------------------
    logic [DVW-1:0] pos_rem_reg;
    logic [DVW-1:0] pos_dvs_reg;
    logic [YW-1:0]  pos_q_reg;
    logic [AW-1:0]  area_reg;
    logic [SW-1:0]  sum_reg  [baf_pkg::NUM_CH];
    logic [SW-1:0]  mrem_reg [baf_pkg::NUM_CH];
    logic [SW-1:0]  mdvs_reg;
    logic [baf_pkg::CHAN_W-1:0] mq_reg [baf_pkg::NUM_CH];

    // Clipped window bounds from the pixel position
    logic [CW-1:0] cx_w, cy_w, r_w, wm1_w, hm1_w;
    logic [CW-1:0] x1_w, x2_w, y1_w, y2_w;
    logic [DW-1:0] span_x, span_y;

    always_comb begin
        cx_w  = CW'(pos_rem_reg[XW-1:0]);
        cy_w  = CW'(pos_q_reg);
        r_w   = CW'(r_eff);
        wm1_w = CW'(w_eff) - CW'(1);
        hm1_w = CW'(h_eff) - CW'(1);
        x1_w  = (cx_w > r_w) ? cx_w - r_w : '0;
        y1_w  = (cy_w > r_w) ? cy_w - r_w : '0;
        x2_w  = (cx_w + r_w > wm1_w) ? wm1_w : cx_w + r_w;
        y2_w  = (cy_w + r_w > hm1_w) ? hm1_w : cy_w + r_w;
        span_x = DW'(x2_reg - x1_reg) + DW'(1);
        span_y = DW'(y2_reg - y1_reg) + DW'(1);
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            baf_pkg::ST_IDLE: begin
                // x/y of the pixel by restoring divide of the emit index by width
                pos_rem_reg <= DVW'(emit_count_reg);
                pos_dvs_reg <= DVW'(w_eff) << (YW - 1);
                pos_q_reg   <= '0;
                step_reg    <= STW'(YW - 1);
                last_reg    <= (32'(emit_next) >= 32'(frame_area));
            end
            baf_pkg::ST_POS: begin
                if (pos_rem_reg >= pos_dvs_reg) begin
                    pos_rem_reg <= pos_rem_reg - pos_dvs_reg;
                    pos_q_reg   <= {pos_q_reg[YW-2:0], 1'b1};
                end else begin
                    pos_q_reg   <= {pos_q_reg[YW-2:0], 1'b0};
                end
                pos_dvs_reg <= pos_dvs_reg >> 1;
                step_reg    <= step_reg - STW'(1);
            end
            baf_pkg::ST_WIN: begin
                x1_reg <= XW'(x1_w);
                x2_reg <= XW'(x2_w);
                y1_reg <= YW'(y1_w);
                y2_reg <= YW'(y2_w);
                xi_reg <= XW'(x1_w);
                yi_reg <= YW'(y1_w);
            end
            baf_pkg::ST_MUL: begin
                area_reg     <= AW'((2 * DW)'(span_x) * (2 * DW)'(span_y));
                row_base_reg <= ADW'(FAW'(y1_reg) * FAW'(w_eff));
                for (int c = 0; c < baf_pkg::NUM_CH; c++) sum_reg[c] <= '0;
            end
            baf_pkg::ST_READ: begin
                if (row_end) begin
                    xi_reg       <= x1_reg;
                    yi_reg       <= yi_reg + YW'(1);
                    row_base_reg <= row_base_reg + ADW'(w_eff);
                end else begin
                    xi_reg <= xi_reg + XW'(1);
                end
            end
            baf_pkg::ST_DIVLD: begin
                for (int c = 0; c < baf_pkg::NUM_CH; c++) mrem_reg[c] <= sum_reg[c];
                mdvs_reg <= SW'(area_reg) << (baf_pkg::CHAN_W - 1);
                step_reg <= STW'(baf_pkg::CHAN_W - 1);
            end
            baf_pkg::ST_DIV: begin
                // mean < 256, so eight restoring steps give the full quotient
                for (int c = 0; c < baf_pkg::NUM_CH; c++) begin
                    if (mrem_reg[c] >= mdvs_reg) begin
                        mrem_reg[c] <= mrem_reg[c] - mdvs_reg;
                        mq_reg[c]   <= {mq_reg[c][baf_pkg::CHAN_W-2:0], 1'b1};
                    end else begin
                        mq_reg[c]   <= {mq_reg[c][baf_pkg::CHAN_W-2:0], 1'b0};
                    end
                end
                mdvs_reg <= mdvs_reg >> 1;
                step_reg <= step_reg - STW'(1);
            end
            default: ;
        endcase

        // accumulate read data in the cycle after each store read
        if (rd_pend_reg) begin
            for (int c = 0; c < baf_pkg::NUM_CH; c++)
                sum_reg[c] <= sum_reg[c]
                    + SW'(rd_data_reg[c*baf_pkg::CHAN_W +: baf_pkg::CHAN_W]);
        end

        if (out_load) begin
            for (int c = 0; c < baf_pkg::NUM_CH; c++)
                m_pixel_out[c*baf_pkg::CHAN_W +: baf_pkg::CHAN_W] <= mq_reg[c];
            m_frame_end <= last_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_emit_needs_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        !frame_loaded_reg |-> emit_count_reg == '0)
        else $error("emit count nonzero without a loaded frame");

    a_read_pend_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == baf_pkg::ST_READ || state_reg == baf_pkg::ST_DRAIN))
        else $error("store read data arrived outside the window walk");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == baf_pkg::ST_OUT && m_valid_reg && !m_ready)
        |=> state_reg == baf_pkg::ST_OUT)
        else $error("result overwrote a pending transaction");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != baf_pkg::ST_IDLE) |-> !mem_we)
        else $error("store written while a drain is in work");

endmodule

`default_nettype wire
